// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the lock core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds outside reset
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that holds at every edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/kpl_pkg.sv -----
// ----------------------------------------------------------------------------
// kpl_pkg
// types, codes and key decode helpers of the keypad passcode lock
// ----------------------------------------------------------------------------
package kpl_pkg;

  // key indices on the "123A456B789C*0#D" layout
  localparam logic [3:0] KEY_STAR  = 4'd12;
  localparam logic [3:0] KEY_POUND = 4'd14;

  // result status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_CLEARED  = 3'd1;
  localparam logic [2:0] ST_CORRECT  = 3'd2;
  localparam logic [2:0] ST_WRONG    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // request kinds from the front end
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  // reset values of the configuration registers
  localparam logic [63:0] CODE_KEYS_RST   = 64'h0000_0000_00B7_3210;
  localparam logic [4:0]  CODE_LENGTH_RST = 5'd6;

  // configuration register indices
  localparam logic CFG_CODE_KEYS   = 1'b0;
  localparam logic CFG_CODE_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] key;
  } kpl_req_t;

  typedef struct packed {
    logic [4:0] entered_count;
    logic [3:0] key_index;
    logic [2:0] status;
  } kpl_res_t;

  // column pins: pin 3 is column 0, then pins 0, 1, 2
  function automatic logic [1:0] decode_column(input logic [3:0] cols);
    logic [1:0] c;
    priority if (!cols[3]) c = 2'd0;
    else if (!cols[0])     c = 2'd1;
    else if (!cols[1])     c = 2'd2;
    else if (!cols[2])     c = 2'd3;
    else                   c = 2'd0;
    return c;
  endfunction

  // rows: lowest active row wins
  function automatic logic [1:0] decode_row(input logic [3:0] rows);
    logic [1:0] r;
    priority if (!rows[0]) r = 2'd0;
    else if (!rows[1])     r = 2'd1;
    else if (!rows[2])     r = 2'd2;
    else if (!rows[3])     r = 2'd3;
    else                   r = 2'd0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/keypad_passcode_lock_core.sv -----
// ----------------------------------------------------------------------------
// keypad_passcode_lock_core
// keypad passcode lock: decode key presses, collect entry, check passcode
// ----------------------------------------------------------------------------
// channel     direction  payload
// s_axis      in         tdata[3:0] column_lines, tdata[7:4] row_lines
// m_axis      out        tdata[2:0] status, [6:3] key_index, [11:7] entered_count
// cfg         in         cfg_index 0 code_keys, 1 code_length
//
// one press accepted per cycle while the queue is not full; its result is
// registered in the result stage after passing through the queue
// rst is synchronous and clears queue, result stage and entry count
// a stalled result holds the back end; the two-entry queue keeps the
// front accepting until it fills
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_passcode_lock_core import kpl_pkg::*; #(
  parameter int MAX_ENTRY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // column_lines, row_lines
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status, key_index, entered_count, zero fill
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] code_keys;
  logic [4:0]  code_length;
  kpl_req_t    front_req;
  kpl_req_t    back_req;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  kpl_res_t    res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_keys   <= CODE_KEYS_RST;
      code_length <= CODE_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_KEYS:   code_keys   <= cfg_data;
        CFG_CODE_LENGTH: code_length <= cfg_data[4:0];
        default:         code_keys   <= code_keys;
      endcase
    end
  end

  // key decode and classify
  kpl_front u_front (
    .column_lines (s_axis_tdata[3:0]),
    .row_lines    (s_axis_tdata[7:4]),
    .req          (front_req)
  );

  assign s_axis_tready = !q_full;

  // request queue
  kpl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_req  (front_req),
    .full      (q_full),
    .pop       (q_pop),
    .pop_req   (back_req),
    .not_empty (q_not_empty)
  );

  // entry handling and result stage
  kpl_back #(
    .MAX_ENTRY (MAX_ENTRY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .req         (back_req),
    .req_valid   (q_not_empty),
    .req_pop     (q_pop),
    .code_keys   (code_keys),
    .code_length (code_length),
    .res         (res),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, res.entered_count, res.key_index, res.status};

  // checks
  `ASSERT_CLK_RST(a_count_bound, clk, rst,
    m_axis_tvalid |-> (m_axis_tdata[11:7] <= 5'(MAX_ENTRY)), "entry count above limit")
  `ASSERT_CLK_RST(a_stored_count, clk, rst,
    (m_axis_tvalid && (m_axis_tdata[2:0] == ST_STORED)) |-> (m_axis_tdata[11:7] != 5'd0),
    "stored key with empty buffer")
  `ASSERT_CLK_RST(a_cleared_count, clk, rst,
    (m_axis_tvalid && (m_axis_tdata[2:0] != ST_STORED)) |-> (m_axis_tdata[11:7] == 5'd0),
    "buffer not empty after clear")
  `ASSERT_CLK_RST(a_full_means_stall, clk, rst, !s_axis_tready |-> m_axis_tvalid,
    "queue full while result stage empty")
  `ASSERT_CLK(a_reset_drains, clk, rst |=> !m_axis_tvalid, "result valid just after reset")

endmodule

// ----- hw/rtl/kpl_front.sv -----
// ----------------------------------------------------------------------------
// kpl_front
// decodes a key press to its index and classifies it for the back end
// ----------------------------------------------------------------------------
module kpl_front import kpl_pkg::*; (
  input  logic [3:0] column_lines,
  input  logic [3:0] row_lines,
  output kpl_req_t   req
);

  logic [3:0] key;

  // row * 4 + column
  assign key = {decode_row(row_lines), decode_column(column_lines)};

  // classify the key
  always_comb begin
    req.key = key;
    priority if (key == KEY_STAR) req.op = OP_CLEAR;
    else if (key == KEY_POUND)    req.op = OP_CHECK;
    else                          req.op = OP_APPEND;
  end

endmodule

// ----- hw/rtl/kpl_queue.sv -----
// ----------------------------------------------------------------------------
// kpl_queue
// two-entry request queue between front and back end
// ----------------------------------------------------------------------------
module kpl_queue import kpl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  kpl_req_t push_req,
  output logic     full,
  input  logic     pop,
  output kpl_req_t pop_req,
  output logic     not_empty
);

  kpl_req_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full      = fill[1];
  assign not_empty = (fill != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_req   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // request storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_req;
  end

endmodule

// ----- hw/rtl/kpl_back.sv -----
// ----------------------------------------------------------------------------
// kpl_back
// entry buffer, passcode compare and registered result stage
// ----------------------------------------------------------------------------
module kpl_back import kpl_pkg::*; #(
  parameter int MAX_ENTRY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  kpl_req_t    req,
  input  logic        req_valid,
  output logic        req_pop,
  input  logic [63:0] code_keys,
  input  logic [4:0]  code_length,
  output kpl_res_t    res,
  output logic        res_valid,
  input  logic        res_ready
);

  localparam int         IDX_W   = (MAX_ENTRY > 1) ? $clog2(MAX_ENTRY) : 1;
  localparam logic [4:0] CNT_MAX = 5'(MAX_ENTRY);

  logic [3:0] entry_keys [MAX_ENTRY];
  logic [4:0] entry_count;
  logic [4:0] entry_count_next;
  logic       code_ok;
  logic       store;
  logic [2:0] status_next;

  // result stage free or draining this cycle
  assign req_pop = req_valid && (!res_valid || res_ready);

  // compare every held key with its passcode nibble
  always_comb begin
    code_ok = (code_length == entry_count);
    for (int i = 0; i < MAX_ENTRY; i++) begin
      if ((5'(i) < entry_count) && (entry_keys[i] != code_keys[4*i +: 4])) begin
        code_ok = 1'b0;
      end
    end
  end

  // carry out the request
  always_comb begin
    store            = 1'b0;
    entry_count_next = 5'd0;
    unique case (req.op)
      OP_CLEAR: status_next = ST_CLEARED;
      OP_CHECK: status_next = code_ok ? ST_CORRECT : ST_WRONG;
      default: begin
        if (entry_count < CNT_MAX) begin
          store            = 1'b1;
          entry_count_next = entry_count + 5'd1;
          status_next      = ST_STORED;
        end else begin
          status_next = ST_OVERFLOW;
        end
      end
    endcase
  end

  // entry count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 5'd0;
      res_valid   <= 1'b0;
    end else begin
      if (req_pop) begin
        entry_count <= entry_count_next;
        res_valid   <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // entry keys and result payload
  always_ff @(posedge clk) begin
    if (req_pop && store) entry_keys[entry_count[IDX_W-1:0]] <= req.key;
    if (req_pop) begin
      res.status        <= status_next;
      res.key_index     <= req.key;
      res.entered_count <= entry_count_next;
    end
  end

endmodule
